FILE: hdl/bpa_pkg.sv
// Package for the bitmap page allocator: sizes, request and response
// structs, operation and status codes, controller states and the command
// and status structs that join the controller and the datapath.
`default_nettype none

package bpa_pkg;

   localparam int MAX_PAGES  = 65536;
   localparam int PAGE_SHIFT = 12;
   localparam int WORD_BITS  = 64;

   localparam int ADDR_W     = 48;
   localparam int CFG_W      = 17;
   localparam int NUM_WORDS  = MAX_PAGES / WORD_BITS;
   localparam int PAGE_IDX_W = $clog2(MAX_PAGES);
   localparam int PAGE_W     = PAGE_IDX_W + 1;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int WORD_IDX_W = PAGE_IDX_W - BIT_W;
   localparam int PG_NUM_W   = ADDR_W - PAGE_SHIFT;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_RESERVE = 2'd2;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_OOM   = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0]        operation;
      logic [ADDR_W-1:0] page_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] granted_address;
      logic [1:0]        status;
   } rsp_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN_UP,
      S_LOAD_LO,
      S_SCAN_LO,
      S_RMW_RD,
      S_RMW_WR,
      S_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic       clear_step;
      logic       capture;
      logic       scan;
      logic       load_lower;
      logic       commit_alloc;
      logic       commit_rmw;
      logic       set_res;
      logic [1:0] res_status;
      logic       rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic range_empty;
      logic hit;
      logic scan_end;
      logic in_range;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: hdl/bpa_datapath.sv
// Datapath of the bitmap page allocator: page bitmap memory, search window,
// free-bit finder, next-search index, page count register and result registers.
// Depends on bpa_pkg; driven by bpa_ctrl through dp_cmd_type.
`default_nettype none

module bpa_datapath
   import bpa_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire dp_cmd_type    cmd,
   output dp_status_type      status,
   input  wire req_type       req_payload,
   input  wire logic          csr_write,
   input  wire logic [CFG_W-1:0] csr_data,
   output rsp_type            rsp_payload
);

   logic [WORD_BITS-1:0]  mem [NUM_WORDS];
   logic [WORD_BITS-1:0]  rd_data_ff;

   logic [CFG_W-1:0]      cfg_ff;
   logic [PAGE_W-1:0]     search_start_ff, search_start_in;
   logic [1:0]            op_ff;
   logic [PAGE_IDX_W-1:0] page_ff;
   logic                  in_range_ff;
   logic [PAGE_W-1:0]     lo_ff, hi_ff;
   logic [WORD_IDX_W-1:0] word_ff, word_in;
   logic [WORD_IDX_W-1:0] chk_word_ff;
   logic                  chk_valid_ff;
   logic [WORD_IDX_W-1:0] clr_cnt_ff;
   rsp_type               res_ff, res_in;
   rsp_type               rsp_ff;

   logic [PAGE_W-1:0]     n_pages;
   logic [PAGE_W-1:0]     wrap_end;
   logic [PG_NUM_W-1:0]   pg_num;
   logic [PAGE_W-1:0]     hi_last;
   logic [WORD_IDX_W-1:0] lo_word, last_word, page_word;
   logic [BIT_W-1:0]      lo_bit, last_bit, hit_bit;
   logic [WORD_BITS-1:0]  mask_lo, mask_hi, cand, onehot, page_mask;
   logic [PAGE_IDX_W-1:0] hit_page;
   logic                  mem_we;
   logic [WORD_IDX_W-1:0] mem_wa, rd_addr;
   logic [WORD_BITS-1:0]  mem_wd;

   // Register values above the bitmap size saturate.
   always_comb begin
      if (32'(cfg_ff) > 32'(MAX_PAGES)) begin
         n_pages = PAGE_W'(MAX_PAGES);
      end else begin
         n_pages = PAGE_W'(cfg_ff);
      end
      wrap_end = (search_start_ff < n_pages) ? search_start_ff : n_pages;
   end

   assign pg_num    = req_payload.page_address[ADDR_W-1:PAGE_SHIFT];
   assign page_word = page_ff[PAGE_IDX_W-1:BIT_W];
   assign page_mask = WORD_BITS'(1) << page_ff[BIT_W-1:0];

   // Search window [lo, hi) and the free pages of the word under test.
   always_comb begin
      hi_last   = hi_ff - PAGE_W'(1);
      last_word = hi_last[PAGE_IDX_W-1:BIT_W];
      last_bit  = hi_last[BIT_W-1:0];
      lo_word   = lo_ff[PAGE_IDX_W-1:BIT_W];
      lo_bit    = lo_ff[BIT_W-1:0];
      mask_lo   = (chk_word_ff == lo_word) ? ({WORD_BITS{1'b1}} << lo_bit) : '1;
      mask_hi   = (chk_word_ff == last_word) ?
                  ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - last_bit)) : '1;
      cand      = ~rd_data_ff & mask_lo & mask_hi;
      onehot    = cand & (~cand + WORD_BITS'(1));
      hit_bit   = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (onehot[i]) begin
            hit_bit = hit_bit | BIT_W'(i);
         end
      end
      hit_page  = {chk_word_ff, hit_bit};
   end

   always_comb begin
      status.clear_last  = (32'(clr_cnt_ff) == 32'(NUM_WORDS - 1));
      status.range_empty = (lo_ff >= hi_ff);
      status.hit         = chk_valid_ff && (cand != '0);
      status.scan_end    = chk_valid_ff && (chk_word_ff == last_word) && (cand == '0);
      status.in_range    = in_range_ff;
   end

   // Single write port shared by the clearing pass, allocation and free/reserve.
   always_comb begin
      mem_we = 1'b0;
      mem_wa = clr_cnt_ff;
      mem_wd = '1;
      if (cmd.clear_step) begin
         mem_we = 1'b1;
      end else if (cmd.commit_alloc) begin
         mem_we = 1'b1;
         mem_wa = chk_word_ff;
         mem_wd = rd_data_ff | onehot;
      end else if (cmd.commit_rmw) begin
         mem_we = 1'b1;
         mem_wa = page_word;
         mem_wd = (op_ff == OP_FREE) ? (rd_data_ff & ~page_mask) : (rd_data_ff | page_mask);
      end
      rd_addr = cmd.scan ? word_ff : page_word;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      word_in = word_ff;
      if (cmd.capture) begin
         word_in = search_start_ff[PAGE_IDX_W-1:BIT_W];
      end else if (cmd.load_lower) begin
         word_in = '0;
      end else if (cmd.scan && (word_ff != last_word)) begin
         word_in = word_ff + WORD_IDX_W'(1);
      end

      search_start_in = search_start_ff;
      if (cmd.commit_alloc) begin
         search_start_in = PAGE_W'(hit_page) + PAGE_W'(1);
      end else if (cmd.commit_rmw && (op_ff == OP_FREE) &&
                   (PAGE_W'(page_ff) < search_start_ff)) begin
         search_start_in = PAGE_W'(page_ff);
      end

      res_in = res_ff;
      if (cmd.commit_alloc) begin
         res_in.granted_address = ADDR_W'(hit_page) << PAGE_SHIFT;
         res_in.status          = STATUS_DONE;
      end else if (cmd.commit_rmw) begin
         res_in.granted_address = '0;
         res_in.status          = STATUS_DONE;
      end else if (cmd.set_res) begin
         res_in.granted_address = '0;
         res_in.status          = cmd.res_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff          <= CFG_W'(MAX_PAGES);
         search_start_ff <= '0;
         clr_cnt_ff      <= '0;
         chk_valid_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            cfg_ff <= csr_data;
         end
         search_start_ff <= search_start_in;
         if (cmd.clear_step) begin
            clr_cnt_ff <= clr_cnt_ff + WORD_IDX_W'(1);
         end
         chk_valid_ff <= cmd.scan;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      chk_word_ff <= word_ff;
      res_ff      <= res_in;
      if (cmd.capture) begin
         op_ff       <= req_payload.operation;
         page_ff     <= pg_num[PAGE_IDX_W-1:0];
         in_range_ff <= (pg_num < PG_NUM_W'(n_pages));
         lo_ff       <= search_start_ff;
         hi_ff       <= n_pages;
      end else if (cmd.load_lower) begin
         lo_ff <= '0;
         hi_ff <= wrap_end;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

FILE: hdl/bpa_ctrl.sv
// Controller of the bitmap page allocator: clearing pass, request intake,
// two-pass next-fit search sequence, free/reserve update and response handoff.
// Depends on bpa_pkg; commands bpa_datapath.
`default_nettype none

module bpa_ctrl
   import bpa_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic [1:0]    req_operation,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output dp_cmd_type         cmd,
   input  wire dp_status_type status
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.res_status = STATUS_DONE;
      req_stall      = 1'b1;

      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               unique case (req_operation) inside
                  OP_ALLOC: begin
                     state_in = S_SCAN_UP;
                  end
                  OP_FREE, OP_RESERVE: begin
                     state_in = S_RMW_RD;
                  end
                  default: begin
                     cmd.set_res = 1'b1;
                     state_in    = S_RESP;
                  end
               endcase
            end
         end
         S_SCAN_UP: begin
            if (status.range_empty) begin
               state_in = S_LOAD_LO;
            end else begin
               cmd.scan = 1'b1;
               if (status.hit) begin
                  cmd.commit_alloc = 1'b1;
                  state_in         = S_RESP;
               end else if (status.scan_end) begin
                  state_in = S_LOAD_LO;
               end
            end
         end
         S_LOAD_LO: begin
            cmd.load_lower = 1'b1;
            state_in       = S_SCAN_LO;
         end
         S_SCAN_LO: begin
            if (status.range_empty) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = STATUS_OOM;
               state_in       = S_RESP;
            end else begin
               cmd.scan = 1'b1;
               if (status.hit) begin
                  cmd.commit_alloc = 1'b1;
                  state_in         = S_RESP;
               end else if (status.scan_end) begin
                  cmd.set_res    = 1'b1;
                  cmd.res_status = STATUS_OOM;
                  state_in       = S_RESP;
               end
            end
         end
         S_RMW_RD: begin
            if (!status.in_range) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = STATUS_RANGE;
               state_in       = S_RESP;
            end else begin
               state_in = S_RMW_WR;
            end
         end
         S_RMW_WR: begin
            cmd.commit_rmw = 1'b1;
            state_in       = S_RESP;
         end
         S_RESP: begin
            // The output register takes the result once the previous one is gone.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: hdl/bitmap_page_allocator.sv
// Bitmap page allocator with next-fit search.
//
// Requests arrive on req_valid / req_stall / req_payload: allocate, free or
// reserve one page. Each request yields exactly one response on rsp_valid /
// rsp_stall / rsp_payload carrying the granted address and a status.
// The page count register is written on csr_valid / csr_ready / csr_data;
// csr_ready is always high. Write it only while no request is in flight.
//
// Allocate scans the bitmap one 64-page word per cycle, first upward from the
// search index to the page count, then from page 0 up to the search index.
// Free and reserve read the bitmap word, then write it back; an unknown code
// gets a done response with no address. The result is loaded into the response
// register as the request finishes; the next request is taken right after,
// even while that response is stalled.
//
// After reset the block runs a clearing pass that marks all pages used, one
// word a cycle over all 1024 words, with req_stall held high; the page count
// resets to 65536 and the search index to 0. While rsp_stall is high the
// response holds, and a finished result waits inside until the register frees.
// Depends on bpa_pkg, bpa_ctrl and bpa_datapath.
`default_nettype none

module bitmap_page_allocator
   import bpa_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_payload,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CFG_W-1:0] csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   bpa_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_payload.operation),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd),
      .status        (status)
   );

   bpa_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .csr_write   (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

FILE: hdl/bpa_checker.sv
// Port-level checks for the bitmap page allocator and the bind that
// attaches them to bitmap_page_allocator. Depends on bpa_pkg.
`default_nettype none

module bpa_checker
   import bpa_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_payload
);

   // The clearing pass follows every reset, so no request is taken right after.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request accepted right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != STATUS_DONE) |->
         (rsp_payload.granted_address == '0))
      else $error("failed request returned an address");

   a_page_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.granted_address[PAGE_SHIFT-1:0] == '0))
      else $error("granted address not page aligned");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for the bitmap page allocator: a scoreboard class
// predicts every response from its own copy of the bitmap and search index.
// Depends on bpa_pkg and bitmap_page_allocator.
`default_nettype none

module tb
   import bpa_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int unsigned RUN_LIMIT = 10_000_000;
   localparam int unsigned NUM_PHASES = 9;

   class alloc_scoreboard;
      bit [WORD_BITS-1:0] used_words [NUM_WORDS];
      logic [PAGE_W-1:0]  search_idx;
      logic [CFG_W-1:0]   page_reg;
      rsp_type            pending_responses [$];
      int unsigned        error_count;

      function new();
         foreach (used_words[i]) used_words[i] = '1;
         search_idx  = '0;
         page_reg    = CFG_W'(MAX_PAGES);
         error_count = 0;
      endfunction

      task report(input string msg);
         if (error_count < 100) $display("ERROR: %s", msg);
         error_count++;
      endtask

      function void write_pages(input logic [CFG_W-1:0] value);
         page_reg = value;
      endfunction

      // Search pages [lo, hi), skipping whole words that are fully used.
      function bit find_free(input int unsigned lo, input int unsigned hi,
                             output int unsigned hit);
         int unsigned p;
         p = lo;
         hit = 0;
         while (p < hi) begin
            if (p % WORD_BITS == 0 && p + WORD_BITS <= hi && &used_words[p / WORD_BITS]) begin
               p += WORD_BITS;
            end else if (!used_words[p / WORD_BITS][p % WORD_BITS]) begin
               hit = p;
               return 1'b1;
            end else begin
               p++;
            end
         end
         return 1'b0;
      endfunction

      function void note_request(input req_type r);
         rsp_type             want;
         int unsigned         n;
         int unsigned         hit;
         int unsigned         wrap_end;
         logic [PG_NUM_W-1:0] pg;
         bit                  found;
         want = '0;
         n = (page_reg > MAX_PAGES) ? MAX_PAGES : page_reg;
         case (r.operation)
            OP_ALLOC: begin
               wrap_end = (search_idx < n) ? search_idx : n;
               found = find_free(search_idx, n, hit);
               if (!found) found = find_free(0, wrap_end, hit);
               if (found) begin
                  used_words[hit / WORD_BITS][hit % WORD_BITS] = 1'b1;
                  search_idx = PAGE_W'(hit + 1);
                  want.granted_address = ADDR_W'(hit) << PAGE_SHIFT;
               end else begin
                  want.status = STATUS_OOM;
               end
            end
            OP_FREE, OP_RESERVE: begin
               pg = r.page_address[ADDR_W-1:PAGE_SHIFT];
               if (pg >= n) begin
                  want.status = STATUS_RANGE;
               end else if (r.operation == OP_FREE) begin
                  used_words[pg / WORD_BITS][pg % WORD_BITS] = 1'b0;
                  if (pg < search_idx) search_idx = PAGE_W'(pg);
               end else begin
                  used_words[pg / WORD_BITS][pg % WORD_BITS] = 1'b1;
               end
            end
            default: begin
            end
         endcase
         pending_responses.push_back(want);
      endfunction

      task check_response(input rsp_type got);
         rsp_type want;
         if (pending_responses.size() == 0) begin
            report($sformatf("unexpected response: address %h status %0d",
                             got.granted_address, got.status));
            return;
         end
         want = pending_responses.pop_front();
         if (got.granted_address !== want.granted_address)
            report($sformatf("granted_address %h, predicted %h",
                             got.granted_address, want.granted_address));
         if (got.status !== want.status)
            report($sformatf("status %0d, predicted %0d", got.status, want.status));
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_payload;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data = '0;

   alloc_scoreboard board = new();
   bit              no_idle = 1'b0;
   int unsigned     cycles_run = 0;

   bitmap_page_allocator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #4 clock = ~clock;

   // Response side: check every accepted response and stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
         board.check_response(rsp_payload);
      rsp_stall <= !no_idle && ($urandom_range(99) < 23);
   end

   initial begin
      while (cycles_run < RUN_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [ADDR_W-1:0] page_address(input int unsigned page);
      return (ADDR_W'(page) << PAGE_SHIFT) | ADDR_W'($urandom_range(4095));
   endfunction

   function automatic req_type pack_request(input logic [1:0] op,
                                            input logic [ADDR_W-1:0] addr);
      req_type r;
      r.operation    = op;
      r.page_address = addr;
      return r;
   endfunction

   function automatic req_type random_request(input int unsigned n);
      req_type     r;
      int unsigned pick;
      pick = $urandom_range(99);
      r.operation = (pick < 42) ? OP_ALLOC : (pick < 76) ? OP_FREE :
                    (pick < 92) ? OP_RESERVE : OP_UNUSED;
      pick = $urandom_range(99);
      if (r.operation == OP_ALLOC || pick >= 88)
         r.page_address = ADDR_W'({$urandom, $urandom});
      else if (pick < 76 && n > 0)
         r.page_address = page_address($urandom_range(n - 1));
      else
         r.page_address = page_address(n + $urandom_range(3));
      return r;
   endfunction

   task automatic send_request(input req_type r);
      if (!no_idle && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic send_op(input logic [1:0] op, input logic [ADDR_W-1:0] addr);
      send_request(pack_request(op, addr));
   endtask

   // Lower valid and wait until every predicted response has been seen.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_page_count(input logic [CFG_W-1:0] value);
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      board.write_pages(value);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned phase_pages [NUM_PHASES];
      int unsigned phase_items [NUM_PHASES];
      int unsigned n;

      phase_pages = '{1, 64, 200, 17, 1000, 131071, 65, 0, 65536};
      phase_items = '{60, 150, 250, 100, 250, 40, 150, 20, 30};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Everything starts used, so the first allocate has nothing to find.
      write_page_count(CFG_W'(MAX_PAGES));
      send_op(OP_ALLOC, '0);
      send_op(OP_FREE, page_address(0));
      send_op(OP_ALLOC, '1);
      send_op(OP_FREE, 48'h0000_0FFF_FFFF);
      send_op(OP_ALLOC, '0);
      send_op(OP_ALLOC, '0);
      send_op(OP_FREE, page_address(MAX_PAGES));
      send_op(OP_FREE, '1);
      send_op(OP_RESERVE, '1);
      send_op(OP_FREE, page_address(5));
      send_op(OP_FREE, page_address(5));
      send_op(OP_RESERVE, page_address(5));
      send_op(OP_RESERVE, page_address(5));
      send_op(OP_ALLOC, '0);
      send_op(OP_UNUSED, '1);
      send_op(OP_FREE, page_address(7));
      send_op(OP_FREE, page_address(3));
      send_op(OP_ALLOC, '0);
      send_op(OP_ALLOC, '0);
      send_op(OP_FREE, page_address(60000));
      send_op(OP_ALLOC, '0);
      drain_responses();

      // The search index now sits far above the lowered page count.
      write_page_count(CFG_W'(40));
      send_op(OP_ALLOC, '0);
      send_op(OP_FREE, page_address(30));
      send_op(OP_ALLOC, '0);
      drain_responses();

      // A register value above the page limit saturates.
      write_page_count('1);
      send_op(OP_FREE, page_address(100));
      send_op(OP_ALLOC, '0);
      drain_responses();

      write_page_count('0);
      send_op(OP_ALLOC, '0);
      send_op(OP_FREE, page_address(0));
      send_op(OP_RESERVE, page_address(0));
      drain_responses();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_page_count(CFG_W'(phase_pages[ph]));
         n = (phase_pages[ph] > MAX_PAGES) ? MAX_PAGES : phase_pages[ph];
         no_idle = (ph == 2);
         for (int i = 0; i < phase_items[ph]; i++) send_request(random_request(n));
         drain_responses();
      end
      no_idle = 1'b0;
      repeat (20) @(posedge clock);

      if (board.pending_responses.size() != 0)
         board.report($sformatf("%0d responses never arrived",
                                board.pending_responses.size()));
      if (board.error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
